FILE: hw/rtl/bounded_uniform_integer_assert.svh
// ----------------------------------------------------------------------------
// Bounded uniform integer assertion macros
// Shared concurrent assertion forms for the block's checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_UNIFORM_INTEGER_ASSERT_SVH
`define BOUNDED_UNIFORM_INTEGER_ASSERT_SVH

// Same-cycle implication, disabled while off is high.
`define BUI_ASSERT_IMPLY(label, clk, off, a, c) \
   label: assert property (@(posedge clk) disable iff (off) (a) |-> (c)) \
      else $error("bounded_uniform_integer: implication failed");

// Next-cycle implication, disabled while off is high.
`define BUI_ASSERT_NEXT(label, clk, off, a, c) \
   label: assert property (@(posedge clk) disable iff (off) (a) |=> (c)) \
      else $error("bounded_uniform_integer: next-cycle check failed");

`endif

FILE: hw/rtl/bui_pkg.sv
// ----------------------------------------------------------------------------
// Bounded uniform integer package
// Widths, register indexes and shared types of the block.
// ----------------------------------------------------------------------------
package bui_pkg;
   localparam int WORD_W = 64;
   localparam int HALF_W = 32;
   localparam int IDX_W  = 2;
   localparam int CNT_W  = $clog2(WORD_W + 1);

   localparam logic [IDX_W-1:0] CSR_WIDTH_MODE   = 2'd0;
   localparam logic [IDX_W-1:0] CSR_RANGE_BOUND  = 2'd1;
   localparam logic [IDX_W-1:0] CSR_RANGE_OFFSET = 2'd2;

   typedef struct packed {
      logic              start;
      logic              mode;
      logic [WORD_W-1:0] bound;
   } thr_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic [WORD_W-1:0] threshold;
   } thr_stat_type;
endpackage

FILE: hw/rtl/bui_thresh.sv
// ----------------------------------------------------------------------------
// Rejection threshold unit
// Works out (2^n - bound) mod bound one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bui_thresh (
   input  logic                  clock,
   input  logic                  reset,
   input  bui_pkg::thr_ctrl_type ctrl,
   output bui_pkg::thr_stat_type stat
);
   import bui_pkg::*;

   logic [WORD_W-1:0] num_ff, num_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic [WORD_W-1:0] thr_ff, thr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W:0]   trial;
   logic [HALF_W-1:0] neg_half;

   always_comb begin
      num_in   = num_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      thr_in   = thr_ff;
      cnt_in   = cnt_ff;
      neg_half = HALF_W'(0) - ctrl.bound[HALF_W-1:0];
      trial    = {rem_ff, num_ff[WORD_W-1]};
      if (ctrl.start) begin
         rem_in = '0;
         if (ctrl.mode) begin
            num_in = WORD_W'(0) - ctrl.bound;
            div_in = ctrl.bound;
         end else begin
            num_in = {{(WORD_W-HALF_W){1'b0}}, neg_half};
            div_in = {{(WORD_W-HALF_W){1'b0}}, ctrl.bound[HALF_W-1:0]};
         end
         if (div_in == '0) begin
            thr_in = '0;
            cnt_in = '0;
         end else begin
            cnt_in = CNT_W'(WORD_W);
         end
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, div_ff}) begin
            trial = trial - {1'b0, div_ff};
         end
         rem_in = trial[WORD_W-1:0];
         num_in = {num_ff[WORD_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            thr_in = trial[WORD_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      if (reset) begin
         thr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         thr_ff <= thr_in;
         cnt_ff <= cnt_in;
      end
   end

   assign stat.busy      = ctrl.start || (cnt_ff != '0);
   assign stat.threshold = thr_ff;
endmodule

FILE: hw/rtl/bounded_uniform_integer.sv
// ----------------------------------------------------------------------------
// Bounded uniform integer
// Maps raw random words without bias onto [offset, offset + bound).
// ----------------------------------------------------------------------------
// One word is taken per cycle while req_stall is low, and a kept word passes
// an entry stage, a stage holding the 32 by 32 multiply in 32-bit mode, 64
// remainder stages of one bit each in 64-bit mode and an output register.
// Rejected words leave a gap. After a write to any of the three registers the
// threshold unit holds req_stall high while it works out the rejection threshold
// one bit per cycle, or for a single cycle when the effective bound is zero.
module bounded_uniform_integer (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [bui_pkg::WORD_W-1:0]   req_random_word,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [bui_pkg::WORD_W-1:0] rsp_ranged_value,
   input  logic                         csr_write,
   input  logic [bui_pkg::IDX_W-1:0]    csr_index,
   input  logic [bui_pkg::WORD_W-1:0]   csr_wdata
);
   import bui_pkg::*;

   localparam int STAGES = WORD_W;

   logic              mode_ff;
   logic [WORD_W-1:0] bound_ff;
   logic [WORD_W-1:0] offset_ff;
   logic              start_ff;
   thr_ctrl_type      thr_ctrl;
   thr_stat_type      thr_stat;
   logic              advance;
   logic              bound_zero;
   logic [HALF_W-1:0] bound_half;

   logic              ent_valid_ff;
   logic [WORD_W-1:0] ent_word_ff;

   logic              valid_ff [STAGES+1];
   logic              keep_ff  [STAGES+1];
   logic [WORD_W-1:0] rem_ff   [STAGES+1];
   logic [WORD_W-1:0] dat_ff   [STAGES+1];
   logic              keep_in  [STAGES+1];
   logic [WORD_W-1:0] rem_in   [STAGES+1];
   logic [WORD_W-1:0] dat_in   [STAGES+1];

   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_value_ff, out_value_in;
   logic [WORD_W:0]   trial;
   logic [HALF_W-1:0] sum_half;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= 1'b0;
         bound_ff  <= '0;
         offset_ff <= '0;
         start_ff  <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         if (csr_write) begin
            unique case (csr_index)
               CSR_WIDTH_MODE: begin
                  mode_ff  <= csr_wdata[0];
                  start_ff <= 1'b1;
               end
               CSR_RANGE_BOUND: begin
                  bound_ff <= csr_wdata;
                  start_ff <= 1'b1;
               end
               CSR_RANGE_OFFSET: begin
                  offset_ff <= csr_wdata;
                  start_ff  <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   assign thr_ctrl.start = start_ff;
   assign thr_ctrl.mode  = mode_ff;
   assign thr_ctrl.bound = bound_ff;

   bui_thresh u_thresh (
      .clock (clock),
      .reset (reset),
      .ctrl  (thr_ctrl),
      .stat  (thr_stat)
   );

   assign bound_half = bound_ff[HALF_W-1:0];
   assign bound_zero = mode_ff ? (bound_ff == '0) : (bound_half == '0);
   assign advance    = !(out_valid_ff && rsp_stall);
   assign req_stall  = !advance || thr_stat.busy;

   always_comb begin
      if (mode_ff) begin
         dat_in[0]  = ent_word_ff;
         keep_in[0] = bound_zero || (ent_word_ff >= thr_stat.threshold);
      end else begin
         dat_in[0]  = {{(WORD_W-HALF_W){1'b0}}, ent_word_ff[HALF_W-1:0]} *
                      {{(WORD_W-HALF_W){1'b0}}, bound_half};
         keep_in[0] = 1'b1;
      end
      rem_in[0] = '0;
      for (int k = 0; k < STAGES; k++) begin
         keep_in[k+1] = keep_ff[k];
         rem_in[k+1]  = rem_ff[k];
         dat_in[k+1]  = dat_ff[k];
         if (mode_ff && !bound_zero) begin
            trial = {rem_ff[k], dat_ff[k][WORD_W-1]};
            if (trial >= {1'b0, bound_ff}) begin
               trial = trial - {1'b0, bound_ff};
            end
            rem_in[k+1] = trial[WORD_W-1:0];
            dat_in[k+1] = {dat_ff[k][WORD_W-2:0], 1'b0};
         end else if (!mode_ff && (k == 0)) begin
            keep_in[k+1] = keep_ff[k] && (bound_zero ||
               ({{(WORD_W-HALF_W){1'b0}}, dat_ff[k][HALF_W-1:0]} >= thr_stat.threshold));
         end
      end
      trial        = '0;
      out_valid_in = valid_ff[STAGES] && keep_ff[STAGES];
      sum_half     = offset_ff[HALF_W-1:0] + dat_ff[STAGES][WORD_W-1:HALF_W];
      if (mode_ff) begin
         out_value_in = offset_ff + rem_ff[STAGES];
      end else begin
         out_value_in = {{(WORD_W-HALF_W){sum_half[HALF_W-1]}}, sum_half};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int k = 0; k <= STAGES; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         ent_valid_ff <= req_valid && !thr_stat.busy;
         valid_ff[0]  <= ent_valid_ff;
         for (int k = 0; k < STAGES; k++) begin
            valid_ff[k+1] <= valid_ff[k];
         end
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         ent_word_ff  <= req_random_word;
         out_value_ff <= out_value_in;
         for (int k = 0; k <= STAGES; k++) begin
            keep_ff[k] <= keep_in[k];
            rem_ff[k]  <= rem_in[k];
            dat_ff[k]  <= dat_in[k];
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_ranged_value = out_value_ff;
endmodule

FILE: hw/rtl/bui_checker.sv
// ----------------------------------------------------------------------------
// Bounded uniform integer checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "bounded_uniform_integer_assert.svh"

module bui_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic [bui_pkg::WORD_W-1:0] rsp_ranged_value,
   input logic                       csr_write,
   input logic [bui_pkg::IDX_W-1:0]  csr_index
);
   import bui_pkg::*;

   `BUI_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)
   `BUI_ASSERT_NEXT(a_cfg_blocks, clock, reset,
      csr_write && (csr_index <= CSR_RANGE_OFFSET), req_stall)
   `BUI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_ranged_value))
   `BUI_ASSERT_IMPLY(a_stall_back, clock, reset, rsp_valid && rsp_stall, req_stall)
endmodule

bind bounded_uniform_integer bui_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_ranged_value (rsp_ranged_value),
   .csr_write        (csr_write),
   .csr_index        (csr_index)
);
